// File: rtl/core/ale_pkg.sv
`timescale 1ns / 1ps
// ale_pkg: shared types and codes for the array list engine.
// No dependencies.
package ale_pkg;

  typedef enum logic [3:0] {
    OP_APPEND      = 4'd0,
    OP_PREPEND     = 4'd1,
    OP_INSERT_AT   = 4'd2,
    OP_UPDATE      = 4'd3,
    OP_READ_FIRST  = 4'd4,
    OP_READ_LAST   = 4'd5,
    OP_READ_AT     = 4'd6,
    OP_REM_FIRST   = 4'd7,
    OP_REM_LAST    = 4'd8,
    OP_REM_AT      = 4'd9,
    OP_SORTED_INS  = 4'd10,
    OP_CLEAR       = 4'd11,
    OP_SEARCH      = 4'd12
  } op_e;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_EMPTY    = 3'd1,
    ST_BADIDX   = 3'd2,
    ST_FULL     = 3'd3,
    ST_NOTFOUND = 3'd4
  } status_e;

  // per-command cell controls, broadcast along the chain
  typedef struct packed {
    logic ins;
    logic rem;
    logic upd;
  } cell_ctrl_t;

  localparam int unsigned InTdataW  = 48;
  localparam int unsigned OutTdataW = 48;

endpackage

// File: rtl/core/ale_cell.sv
`timescale 1ns / 1ps
// ale_cell: one list entry; shifts with its neighbours and compares with the request value.
// Depends on ale_pkg.
module ale_cell #(
  parameter int unsigned IDX        = 0,
  parameter int unsigned IDX_W      = 6,
  parameter int unsigned DATA_WIDTH = 32
) (
  input  logic                    clk_i,
  input  ale_pkg::cell_ctrl_t     ctrl_i,
  input  logic [IDX_W-1:0]        pos_i,
  input  logic [DATA_WIDTH-1:0]   val_i,
  input  logic [DATA_WIDTH-1:0]   left_i,
  input  logic [DATA_WIDTH-1:0]   right_i,
  output logic [DATA_WIDTH-1:0]   entry_o,
  output logic                    eq_o,
  output logic                    gt_o
);
  import ale_pkg::*;

  localparam logic [IDX_W-1:0] MyIdx = IDX_W'(IDX);

  logic [DATA_WIDTH-1:0] entry_q, entry_d;

  always_comb begin
    entry_d = entry_q;
    if (ctrl_i.ins) begin
      if (MyIdx == pos_i) entry_d = val_i;
      else if (MyIdx > pos_i) entry_d = left_i;
    end else if (ctrl_i.rem) begin
      if (MyIdx >= pos_i) entry_d = right_i;
    end else if (ctrl_i.upd) begin
      if (MyIdx == pos_i) entry_d = val_i;
    end
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

  assign entry_o = entry_q;
  assign eq_o    = (entry_q == val_i);
  assign gt_o    = ($signed(val_i) < $signed(entry_q));

endmodule

// File: rtl/core/array_list_engine.sv
`timescale 1ns / 1ps
// array_list_engine: fixed-capacity ordered list built as a chain of entry cells.
// Depends on ale_pkg and ale_cell.
//
//  Port group  Dir  Fields (low bit up)
//  s_axis      in   opcode[3:0], item_value[35:4], position[42:36], zero pad
//  m_axis      out  result_value[31:0], status[34:32], count_after[41:35], found_index[47:42]
//
// One request per cycle while the output is not stalled: every command completes across all cells at once,
// shifts and compares happen in each cell at once, the result lands in an output register.
// A new request is taken while the output register is empty or being drained.
// Reset clears the count and the output valid; entry contents are undefined until written.
module array_list_engine #(
  parameter int unsigned CAPACITY   = 64,
  parameter int unsigned DATA_WIDTH = 32
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  input  logic [ale_pkg::InTdataW-1:0]    s_axis_tdata,  // opcode, item_value, position
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  output logic [ale_pkg::OutTdataW-1:0]   m_axis_tdata   // result, status, count, found
);
  import ale_pkg::*;

  localparam int unsigned IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int unsigned CNT_W = $clog2(CAPACITY + 1);
  localparam int unsigned CMP_W = (CNT_W > 7) ? CNT_W : 7;
  localparam logic [CNT_W-1:0] CapCnt = CNT_W'(CAPACITY);

  logic [3:0]            opcode;
  logic signed [31:0]    item_value;
  logic [6:0]            position;
  logic signed [63:0]    val_ext;
  logic [DATA_WIDTH-1:0] val;

  assign opcode     = s_axis_tdata[3:0];
  assign item_value = s_axis_tdata[35:4];
  assign position   = s_axis_tdata[42:36];
  assign val_ext    = 64'(item_value);
  assign val        = val_ext[DATA_WIDTH-1:0];

  logic accept;
  logic out_valid_q;
  logic [OutTdataW-1:0] out_data_q;
  logic [CNT_W-1:0] count_q, count_d;

  assign s_axis_tready = !out_valid_q || m_axis_tready;
  assign accept        = s_axis_tvalid && s_axis_tready;

  // cell chain
  logic [DATA_WIDTH-1:0] entries [CAPACITY];
  logic [CAPACITY-1:0]   eq_vec, gt_vec;
  cell_ctrl_t            ctrl, ctrl_gated;
  logic [IDX_W-1:0]      pos_sel;

  assign ctrl_gated = accept ? ctrl : '0;

  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    logic [DATA_WIDTH-1:0] left, right;
    if (g == 0) begin : g_first
      assign left = val;
    end else begin : g_mid_l
      assign left = entries[g-1];
    end
    if (g == CAPACITY - 1) begin : g_last
      assign right = entries[g];
    end else begin : g_mid_r
      assign right = entries[g+1];
    end
    ale_cell #(
      .IDX        (g),
      .IDX_W      (IDX_W),
      .DATA_WIDTH (DATA_WIDTH)
    ) u_cell (
      .clk_i   (clk_i),
      .ctrl_i  (ctrl_gated),
      .pos_i   (pos_sel),
      .val_i   (val),
      .left_i  (left),
      .right_i (right),
      .entry_o (entries[g]),
      .eq_o    (eq_vec[g]),
      .gt_o    (gt_vec[g])
    );
  end

  // first-match encoders over held entries
  logic [IDX_W-1:0] hit_idx, sort_idx;
  logic             hit, sort_hit;

  always_comb begin
    hit      = 1'b0;
    sort_hit = 1'b0;
    hit_idx  = '0;
    sort_idx = '0;
    for (int i = CAPACITY - 1; i >= 0; i--) begin
      if (CNT_W'(i) < count_q) begin
        if (eq_vec[i]) begin
          hit     = 1'b1;
          hit_idx = IDX_W'(i);
        end
        if (gt_vec[i]) begin
          sort_hit = 1'b1;
          sort_idx = IDX_W'(i);
        end
      end
    end
  end

  logic [CMP_W-1:0]  pos_w, cnt_w;
  logic              full, empty;
  logic              rd_en;
  logic [IDX_W-1:0]  rd_idx, last_idx;
  logic [63:0]       rd_ext;
  logic [31:0]       res;
  status_e           st;
  logic [5:0]        found;

  assign pos_w    = CMP_W'(position);
  assign cnt_w    = CMP_W'(count_q);
  assign full     = (count_q == CapCnt);
  assign empty    = (count_q == '0);
  assign last_idx = IDX_W'(count_q - CNT_W'(1));

  always_comb begin
    ctrl    = '0;
    pos_sel = IDX_W'(pos_w);
    count_d = count_q;
    rd_en   = 1'b0;
    rd_idx  = IDX_W'(pos_w);
    st      = ST_OK;
    found   = '0;
    unique case (opcode) inside
      OP_APPEND, OP_PREPEND: begin
        if (full) st = ST_FULL;
        else begin
          ctrl.ins = 1'b1;
          pos_sel  = (opcode == OP_APPEND) ? IDX_W'(count_q) : '0;
          count_d  = count_q + CNT_W'(1);
        end
      end
      OP_INSERT_AT: begin
        if (pos_w > cnt_w) st = ST_BADIDX;
        else if (full) st = ST_FULL;
        else begin
          ctrl.ins = 1'b1;
          count_d  = count_q + CNT_W'(1);
        end
      end
      OP_UPDATE: begin
        if (pos_w >= cnt_w) st = ST_BADIDX;
        else ctrl.upd = 1'b1;
      end
      OP_READ_FIRST, OP_READ_LAST, OP_REM_FIRST, OP_REM_LAST: begin
        if (empty) st = ST_EMPTY;
        else begin
          rd_en  = 1'b1;
          rd_idx = (opcode == OP_READ_FIRST || opcode == OP_REM_FIRST) ? '0 : last_idx;
          pos_sel = rd_idx;
          if (opcode == OP_REM_FIRST || opcode == OP_REM_LAST) begin
            ctrl.rem = 1'b1;
            count_d  = count_q - CNT_W'(1);
          end
        end
      end
      OP_READ_AT, OP_REM_AT: begin
        if (pos_w >= cnt_w) st = ST_BADIDX;
        else begin
          rd_en = 1'b1;
          if (opcode == OP_REM_AT) begin
            ctrl.rem = 1'b1;
            count_d  = count_q - CNT_W'(1);
          end
        end
      end
      OP_SORTED_INS: begin
        if (full) st = ST_FULL;
        else begin
          ctrl.ins = 1'b1;
          pos_sel  = sort_hit ? sort_idx : IDX_W'(count_q);
          count_d  = count_q + CNT_W'(1);
        end
      end
      OP_CLEAR: count_d = '0;
      OP_SEARCH: begin
        if (hit) found = 6'(hit_idx);
        else st = ST_NOTFOUND;
      end
      default: ;
    endcase
  end

  assign rd_ext = 64'($signed(entries[rd_idx]));
  assign res    = rd_en ? rd_ext[31:0] : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (accept) begin
        count_q     <= count_d;
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      out_data_q <= {found, 7'(count_d), st, res};
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CapCnt) else $error("count above capacity");

  a_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && opcode == OP_CLEAR |=> count_q == '0) else $error("clear did not empty list");

  a_full_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && full && (opcode == OP_APPEND || opcode == OP_PREPEND ||
                       opcode == OP_SORTED_INS) |=> count_q == $past(count_q))
    else $error("insert into full list changed count");

  a_result_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> m_axis_tvalid) else $error("accepted request produced no result");

endmodule
